// ----- src/quaternion_relative_rotation_unit_macros.svh -----
// Assertion macros shared by the quaternion relative rotation unit.
`ifndef QUATERNION_RELATIVE_ROTATION_UNIT_MACROS_SVH
`define QUATERNION_RELATIVE_ROTATION_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QRR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define QRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qrr assertion failed");

`endif

// ----- src/qrr_pkg.sv -----
// Package: shared constants and status codes of the relative rotation unit.
`timescale 1ns / 1ps
package qrr_pkg;
    localparam int WORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int QUEUE_DEPTH   = 2;
    localparam int STATUS_BITS   = 2;

    typedef enum logic [STATUS_BITS-1:0] {
        STAT_OK   = 2'd0,
        STAT_ZERO = 2'd1,
        STAT_SAT  = 2'd2
    } status_t;
endpackage

// ----- src/qrr_front.sv -----
// Front end: products of the Hamilton product and norm, then their sums.
`timescale 1ns / 1ps
module qrr_front #(
    parameter int WORD_BITS = qrr_pkg::WORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic signed [WORD_BITS-1:0]       a_w,
    input  logic signed [WORD_BITS-1:0]       a_x,
    input  logic signed [WORD_BITS-1:0]       a_y,
    input  logic signed [WORD_BITS-1:0]       a_z,
    input  logic signed [WORD_BITS-1:0]       b_w,
    input  logic signed [WORD_BITS-1:0]       b_x,
    input  logic signed [WORD_BITS-1:0]       b_y,
    input  logic signed [WORD_BITS-1:0]       b_z,
    output logic                              out_valid,
    output logic [4*(2*WORD_BITS+2)+2*WORD_BITS:0] out_data
);
    localparam int MW = 2 * WORD_BITS;
    localparam int PW = 2 * WORD_BITS + 2;
    localparam int NW = 2 * WORD_BITS + 1;

    logic signed [MW-1:0] p_reg [0:3][0:3];
    logic signed [MW-1:0] n_reg [0:3];
    logic                 v1_reg;
    logic signed [PW-1:0] c_reg [0:3];
    logic [NW-1:0]        norm_reg;
    logic                 v2_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // stage 1: products, ordered so each component is + - - + (w is + + + +)
    always_ff @(posedge clk)
    begin
        p_reg[0][0] <= a_w * b_w; p_reg[0][1] <= a_x * b_x;
        p_reg[0][2] <= a_y * b_y; p_reg[0][3] <= a_z * b_z;
        p_reg[1][0] <= a_w * b_x; p_reg[1][1] <= a_x * b_w;
        p_reg[1][2] <= a_y * b_z; p_reg[1][3] <= a_z * b_y;
        p_reg[2][0] <= a_w * b_y; p_reg[2][1] <= a_y * b_w;
        p_reg[2][2] <= a_z * b_x; p_reg[2][3] <= a_x * b_z;
        p_reg[3][0] <= a_w * b_z; p_reg[3][1] <= a_z * b_w;
        p_reg[3][2] <= a_x * b_y; p_reg[3][3] <= a_y * b_x;
        n_reg[0] <= a_w * a_w; n_reg[1] <= a_x * a_x;
        n_reg[2] <= a_y * a_y; n_reg[3] <= a_z * a_z;
    end

    // stage 2: sums
    always_ff @(posedge clk)
    begin
        c_reg[0] <= PW'(p_reg[0][0]) + PW'(p_reg[0][1]) + PW'(p_reg[0][2])
                  + PW'(p_reg[0][3]);
        for (int k = 1; k < 4; k++)
        begin
            c_reg[k] <= PW'(p_reg[k][0]) - PW'(p_reg[k][1]) - PW'(p_reg[k][2])
                      + PW'(p_reg[k][3]);
        end
        norm_reg <= NW'($unsigned(n_reg[0])) + NW'($unsigned(n_reg[1]))
                  + NW'($unsigned(n_reg[2])) + NW'($unsigned(n_reg[3]));
    end

    assign out_valid = v2_reg;
    assign out_data  = {c_reg[3], c_reg[2], c_reg[1], c_reg[0], norm_reg};
endmodule

// ----- src/qrr_queue.sv -----
// Short queue between front and back end.
`timescale 1ns / 1ps
`include "quaternion_relative_rotation_unit_macros.svh"
module qrr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qrr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [AW-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]    count_reg, count_next;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

    assign pop_data = mem_reg[rd_reg];
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    `QRR_ASSERT_IMPL(a_no_overflow, push && full && !pop, 1'b0)
    `QRR_ASSERT_IMPL(a_no_underflow, pop, count_reg != '0)
    `QRR_ASSERT_NEXT(a_count_tracks, push && !pop && !full, count_reg != '0)
endmodule

// ----- src/qrr_back.sv -----
// Back end: pipelined restoring division of four lanes by the norm, saturation.
`timescale 1ns / 1ps
module qrr_back #(
    parameter int WORD_BITS = qrr_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [4*(2*WORD_BITS+2)+2*WORD_BITS:0] in_data,
    output logic                              done,
    output logic signed [WORD_BITS-1:0]       r_w,
    output logic signed [WORD_BITS-1:0]       r_x,
    output logic signed [WORD_BITS-1:0]       r_y,
    output logic signed [WORD_BITS-1:0]       r_z,
    output logic [qrr_pkg::STATUS_BITS-1:0]   status
);
    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W + 2;
    localparam int NW = 2 * W + 1;
    localparam int DW = 3 * W + FRAC_BITS + 3;

    logic [PW-1:0] comp_in [0:3];
    logic [NW-1:0] norm_in;

    logic [DW-1:0] rem_reg  [0:W][0:3];
    logic [DW-1:0] rem_next [0:W][0:3];
    logic [W-1:0]  q_reg    [0:W][0:3];
    logic [W-1:0]  q_next   [0:W][0:3];
    logic          sat_reg  [0:W][0:3];
    logic          sat_next [0:3];
    logic          neg_reg  [0:W][0:3];
    logic          neg_next [0:3];
    logic [NW-1:0] norm_reg [0:W];
    logic          zero_reg [0:W];
    logic          vld_reg  [0:W];

    logic [W-1:0]  res_next [0:3];
    logic          any_sat;
    logic          done_reg;
    logic [W-1:0]  r_reg [0:3];
    qrr_pkg::status_t status_reg, status_next;

    assign norm_in = in_data[NW-1:0];
    for (genvar l = 0; l < 4; l++)
    begin : g_unpack
        assign comp_in[l] = in_data[NW + l*PW +: PW];
    end

    // entry: magnitude, scaled dividend and overflow test
    always_comb
    begin
        logic [PW-1:0] mag;
        logic [DW-1:0] ns;
        ns = DW'(norm_in) << (W - 1);
        for (int l = 0; l < 4; l++)
        begin
            neg_next[l] = comp_in[l][PW-1];
            mag = neg_next[l] ? (~comp_in[l] + 1'b1) : comp_in[l];
            rem_next[0][l] = DW'(mag) << FRAC_BITS;
            q_next[0][l]   = '0;
            sat_next[l] = neg_next[l] ? (rem_next[0][l] >= ns + DW'(norm_in))
                                      : (rem_next[0][l] >= ns);
        end
        // one quotient bit per stage, most significant first
        for (int j = 1; j <= W; j++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (rem_reg[j-1][l] >= (DW'(norm_reg[j-1]) << (W - j)))
                begin
                    rem_next[j][l] = rem_reg[j-1][l] - (DW'(norm_reg[j-1]) << (W - j));
                    q_next[j][l]   = {q_reg[j-1][l][W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[j][l] = rem_reg[j-1][l];
                    q_next[j][l]   = {q_reg[j-1][l][W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j <= W; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int j = 1; j <= W; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            done_reg <= vld_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg[0] <= norm_in;
        zero_reg[0] <= (norm_in == '0);
        for (int l = 0; l < 4; l++)
        begin
            rem_reg[0][l] <= rem_next[0][l];
            q_reg[0][l]   <= q_next[0][l];
            sat_reg[0][l] <= sat_next[l];
            neg_reg[0][l] <= neg_next[l];
        end
        for (int j = 1; j <= W; j++)
        begin
            norm_reg[j] <= norm_reg[j-1];
            zero_reg[j] <= zero_reg[j-1];
            for (int l = 0; l < 4; l++)
            begin
                rem_reg[j][l] <= rem_next[j][l];
                q_reg[j][l]   <= q_next[j][l];
                sat_reg[j][l] <= sat_reg[j-1][l];
                neg_reg[j][l] <= neg_reg[j-1][l];
            end
        end
    end

    // exit: clamp, restore sign, zero-norm override
    always_comb
    begin
        logic [W-1:0] mag_q;
        any_sat = 1'b0;
        for (int l = 0; l < 4; l++)
        begin
            if (sat_reg[W][l])
            begin
                mag_q = neg_reg[W][l] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - 1'b1);
            end
            else
            begin
                mag_q = q_reg[W][l];
            end
            any_sat = any_sat | sat_reg[W][l];
            res_next[l] = zero_reg[W] ? '0 : (neg_reg[W][l] ? (~mag_q + 1'b1) : mag_q);
        end
        if (zero_reg[W])
        begin
            status_next = qrr_pkg::STAT_ZERO;
        end
        else if (any_sat)
        begin
            status_next = qrr_pkg::STAT_SAT;
        end
        else
        begin
            status_next = qrr_pkg::STAT_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 4; l++)
        begin
            r_reg[l] <= res_next[l];
        end
        status_reg <= status_next;
    end

    assign done   = done_reg;
    assign r_w    = r_reg[0];
    assign r_x    = r_reg[1];
    assign r_y    = r_reg[2];
    assign r_z    = r_reg[3];
    assign status = status_reg;
endmodule

// ----- src/quaternion_relative_rotation_unit.sv -----
// Top level: relative rotation inverse(a) * b of two fixed-point quaternions.
`timescale 1ns / 1ps
`include "quaternion_relative_rotation_unit_macros.svh"
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------
//  command  | in        | start high, busy low | a_w a_x a_y a_z b_w b_x b_y b_z
//  result   | out       | done, one cycle    | r_w r_x r_y r_z status
//
// One transaction is taken every cycle while busy is low; each result follows its
// command through the product and sum stages of the front end, the queue, and the
// one-bit-per-stage division pipeline in the back end.
// Reset (rst_n low, asynchronous) empties every stage and the queue.
// The receiver cannot stall: the back end drains the queue every cycle, so busy
// stays low in normal use and rises only if the queue were ever to fill.
module quaternion_relative_rotation_unit #(
    parameter int WORD_BITS = qrr_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = qrr_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [WORD_BITS-1:0]     a_w,
    input  logic signed [WORD_BITS-1:0]     a_x,
    input  logic signed [WORD_BITS-1:0]     a_y,
    input  logic signed [WORD_BITS-1:0]     a_z,
    input  logic signed [WORD_BITS-1:0]     b_w,
    input  logic signed [WORD_BITS-1:0]     b_x,
    input  logic signed [WORD_BITS-1:0]     b_y,
    input  logic signed [WORD_BITS-1:0]     b_z,
    output logic                            done,
    output logic signed [WORD_BITS-1:0]     r_w,
    output logic signed [WORD_BITS-1:0]     r_x,
    output logic signed [WORD_BITS-1:0]     r_y,
    output logic signed [WORD_BITS-1:0]     r_z,
    output logic [qrr_pkg::STATUS_BITS-1:0] status
);
    // flattened transaction: four product components and the norm
    localparam int XW  = 4 * (2 * WORD_BITS + 2) + 2 * WORD_BITS + 1;
    localparam int LAT = WORD_BITS + 5;

    logic          accept;
    logic          front_valid;
    logic [XW-1:0] front_data;
    logic [XW-1:0] queue_data;
    logic          queue_empty;
    logic          queue_full;
    logic          queue_pop;

    // take a command only while the queue has room
    assign accept    = start && !busy;
    assign busy      = queue_full;
    // drain the queue every cycle; the back end never stalls
    assign queue_pop = !queue_empty;

    qrr_front #(
        .WORD_BITS(WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a_w       (a_w),
        .a_x       (a_x),
        .a_y       (a_y),
        .a_z       (a_z),
        .b_w       (b_w),
        .b_x       (b_x),
        .b_y       (b_y),
        .b_z       (b_z),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    qrr_queue #(
        .WIDTH(XW),
        .DEPTH(qrr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_data (front_data),
        .pop       (queue_pop),
        .pop_data  (queue_data),
        .empty     (queue_empty),
        .full      (queue_full)
    );

    qrr_back #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (queue_pop),
        .in_data  (queue_data),
        .done     (done),
        .r_w      (r_w),
        .r_x      (r_x),
        .r_y      (r_y),
        .r_z      (r_z),
        .status   (status)
    );

    // every result is matched by an earlier accepted command
    `QRR_ASSERT_IMPL(a_latency, $past(rst_n, LAT), done == $past(accept, LAT))
    `QRR_ASSERT_IMPL(a_zero_status, done && status == qrr_pkg::STAT_ZERO, r_w == '0 && r_x == '0)
endmodule
